// ===== rtl/hrfp_pkg.sv =====
`timescale 1ns / 1ps

package hrfp_pkg;

	// Width of the decimal and hex length accumulators (saturating).
	localparam int LENGTH_BITS      = 32;
	localparam int LEN_NAME_BYTES   = 16;
	localparam int CHUNK_NAME_BYTES = 25;
	localparam int SHORT_LINE       = 3;
	localparam int POS_BITS         = 5;
	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	// Header names in lower case; first character in the top byte.
	localparam logic [8*LEN_NAME_BYTES-1:0]   LEN_NAME   = "content-length: ";
	localparam logic [8*CHUNK_NAME_BYTES-1:0] CHUNK_NAME = "transfer-encoding: chunke";

	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_PRINT_LO = 8'h21;
	localparam logic [7:0] CH_PRINT_HI = 8'h7F;

	typedef enum logic [2:0] {
		PH_REQ   = 3'd0,
		PH_HDR   = 3'd1,
		PH_BODY  = 3'd2,
		PH_CSIZE = 3'd3,
		PH_CDATA = 3'd4,
		PH_CEND  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		FR_NONE  = 2'd0,
		FR_LEN   = 2'd1,
		FR_CHUNK = 2'd2
	} framing_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	function automatic logic [7:0] len_name_char(input logic [POS_BITS-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < LEN_NAME_BYTES; i++) begin
			if (pos == POS_BITS'(i)) begin
				c = LEN_NAME[8*(LEN_NAME_BYTES-1-i) +: 8];
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] chunk_name_char(input logic [POS_BITS-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < CHUNK_NAME_BYTES; i++) begin
			if (pos == POS_BITS'(i)) begin
				c = CHUNK_NAME[8*(CHUNK_NAME_BYTES-1-i) +: 8];
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/http_request_framing_parser_top.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | Signals                       | Content
// ---------+-----+-------------------------------+-------------------------------------------
// s_axis   | in  | tvalid tready tdata[7:0]      | tdata: data_byte
// m_axis   | out | tvalid tready tdata[7:0]      | tdata: out_byte
//          |     | tlast tuser[3:0]              | tlast: message_end
//          |     |                               | tuser: insert_point [0], phase [3:1]
//
// One byte per clock sustained while m_axis_tready stays high. A byte is registered
// on acceptance, parsed from the input register and lands in the output register.
// The throughput limit is the per-byte update of the parser state (the
// saturating x10 / x16 accumulators and the remaining-count decrement).
// arst_n clears the parser state and both valid flags; no clearing pass.
// A stalled output holds its transaction while one more byte waits in the input
// register; s_axis_tready drops only when both are full and m_axis_tready is low.

module http_request_framing_parser_top
	import hrfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast,   // message_end
	output logic [3:0] m_axis_tuser    // [0] insert_point, [3:1] phase
);

	// input register
	logic [7:0] byte_s1;
	logic       valid_s1;

	// output register
	logic [7:0] byte_s2;
	logic       ins_s2;
	logic       fin_s2;
	phase_t     phase_s2;
	logic       valid_s2;

	// parser state
	phase_t                  phase_q;
	logic [POS_BITS-1:0]     pos_q;
	logic                    len_match_q;
	logic                    chk_match_q;
	logic [LENGTH_BITS-1:0]  dec_q;
	logic                    dv_q;
	logic                    run_q;
	framing_t                kind_q;
	logic [LENGTH_BITS-1:0]  rc_q;
	logic                    last_q;

	phase_t                  n_phase;
	logic [POS_BITS-1:0]     n_pos;
	logic                    n_len_match;
	logic                    n_chk_match;
	logic [LENGTH_BITS-1:0]  n_dec;
	logic                    n_dv;
	logic                    n_run;
	framing_t                n_kind;
	logic [LENGTH_BITS-1:0]  n_rc;
	logic                    n_last;
	logic                    ins;
	logic                    fin;
	logic                    clr;

	logic                    advance;

	logic [7:0]              lb;
	logic                    is_lf;
	logic                    is_digit;
	logic                    is_hex;
	logic [3:0]              hex_digit;
	logic [LENGTH_BITS+3:0]  dec_wide;
	logic [LENGTH_BITS-1:0]  dec_acc;
	logic [LENGTH_BITS-1:0]  hex_acc;
	logic [LENGTH_BITS-1:0]  rc_dec;

	// pipeline moves whenever the output slot is free or being emptied
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// byte classification
	assign lb       = to_lower(byte_s1);
	assign is_lf    = (byte_s1 == CH_LF);
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign is_hex   = is_digit || ((lb >= CH_LOWER_A) && (lb <= CH_LOWER_F));
	// 'a'..'f' low nibble is 1..6, so +9 gives 10..15
	assign hex_digit = is_digit ? byte_s1[3:0] : (lb[3:0] + 4'd9);

	// v*10 + d by shifts; any carry into the top nibble means overflow
	assign dec_wide = {1'b0, dec_q, 3'b000} + {3'b000, dec_q, 1'b0}
		+ {{LENGTH_BITS{1'b0}}, byte_s1[3:0]};
	assign dec_acc  = (dec_wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? '1
		: dec_wide[LENGTH_BITS-1:0];
	assign hex_acc  = (rc_q[LENGTH_BITS-1:LENGTH_BITS-4] != 4'd0) ? '1
		: {rc_q[LENGTH_BITS-5:0], hex_digit};
	assign rc_dec   = (rc_q != '0) ? (rc_q - LENGTH_BITS'(1)) : rc_q;

	always_comb begin
		n_phase     = phase_q;
		n_pos       = pos_q;
		n_len_match = len_match_q;
		n_chk_match = chk_match_q;
		n_dec       = dec_q;
		n_dv        = dv_q;
		n_run       = run_q;
		n_kind      = kind_q;
		n_rc        = rc_q;
		n_last      = last_q;
		ins         = 1'b0;
		fin         = 1'b0;
		clr         = 1'b0;

		unique case (phase_q)
			PH_HDR: begin
				if (!is_lf) begin
					if (pos_q < POS_BITS'(LEN_NAME_BYTES) && lb != len_name_char(pos_q)) begin
						n_len_match = 1'b0;
					end
					if (pos_q < POS_BITS'(CHUNK_NAME_BYTES) && lb != chunk_name_char(pos_q)) begin
						n_chk_match = 1'b0;
					end
					// value digits start right after the name
					if (pos_q == POS_BITS'(LEN_NAME_BYTES) && is_digit) begin
						n_dv  = 1'b1;
						n_run = 1'b1;
					end else if (run_q && !is_digit) begin
						n_run = 1'b0;
					end
					if (n_run) begin
						n_dec = dec_acc;
					end
					if (pos_q != POS_MAX) begin
						n_pos = pos_q + POS_BITS'(1);
					end
				end else if (pos_q < POS_BITS'(SHORT_LINE)) begin
					// blank line: headers are over
					if (kind_q == FR_LEN && rc_q != '0) begin
						n_phase = PH_BODY;
					end else if (kind_q == FR_CHUNK) begin
						n_phase = PH_CSIZE;
						n_rc    = '0;
					end else begin
						n_phase = PH_REQ;
						fin     = 1'b1;
					end
					clr = 1'b1;
				end else begin
					if (len_match_q && dv_q) begin
						n_kind = FR_LEN;
						n_rc   = dec_q;
					end
					if (chk_match_q && pos_q >= POS_BITS'(CHUNK_NAME_BYTES)) begin
						n_kind = FR_CHUNK;
					end
					clr = 1'b1;
				end
			end
			PH_BODY, PH_CDATA: begin
				n_rc = rc_dec;
				if (rc_dec == '0) begin
					if (phase_q == PH_BODY) begin
						n_phase = PH_REQ;
						fin     = 1'b1;
					end else begin
						n_phase = PH_CEND;
					end
				end
			end
			PH_CSIZE: begin
				if (byte_s1 >= CH_PRINT_LO && byte_s1 <= CH_PRINT_HI) begin
					if (is_hex) begin
						n_rc = hex_acc;
					end
				end else if (is_lf) begin
					n_last  = (rc_q == '0);
					n_phase = (rc_q == '0) ? PH_CEND : PH_CDATA;
				end
			end
			PH_CEND: begin
				if (is_lf) begin
					if (last_q) begin
						n_phase = PH_REQ;
						fin     = 1'b1;
					end else begin
						n_phase = PH_CSIZE;
					end
					n_rc   = '0;
					n_last = 1'b0;
				end
			end
			default: begin
				// request line, and the unused codes
				n_phase = PH_REQ;
				if (is_lf) begin
					n_phase = PH_HDR;
					ins     = 1'b1;
					n_kind  = FR_NONE;
					n_rc    = '0;
					clr     = 1'b1;
				end
			end
		endcase

		if (clr) begin
			n_pos       = '0;
			n_len_match = 1'b1;
			n_chk_match = 1'b1;
			n_dec       = '0;
			n_dv        = 1'b0;
			n_run       = 1'b0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// parser state, updated once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_REQ;
			pos_q       <= '0;
			len_match_q <= 1'b1;
			chk_match_q <= 1'b1;
			dec_q       <= '0;
			dv_q        <= 1'b0;
			run_q       <= 1'b0;
			kind_q      <= FR_NONE;
			rc_q        <= '0;
			last_q      <= 1'b0;
		end else if (advance) begin
			phase_q     <= n_phase;
			pos_q       <= n_pos;
			len_match_q <= n_len_match;
			chk_match_q <= n_chk_match;
			dec_q       <= n_dec;
			dv_q        <= n_dv;
			run_q       <= n_run;
			kind_q      <= n_kind;
			rc_q        <= n_rc;
			last_q      <= n_last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s2  <= byte_s1;
			ins_s2   <= ins;
			fin_s2   <= fin;
			phase_s2 <= n_phase;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = byte_s2;
	assign m_axis_tlast  = fin_s2;
	assign m_axis_tuser  = {phase_s2, ins_s2};

endmodule

// ===== rtl/hrfp_checker.sv =====
`timescale 1ns / 1ps

module hrfp_checker
	import hrfp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic [3:0] m_axis_tuser
);

	// insert point only on the newline that opens the headers
	a_insert_on_lf: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0]
			|-> m_axis_tdata == CH_LF && m_axis_tuser[3:1] == PH_HDR)
		else $error("insert point not on request line newline");

	// a finished message always drops back to the request line
	a_end_to_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[3:1] == PH_REQ)
		else $error("message end without return to request line");

	// the next byte after an insert point is still in the headers or ends them
	a_after_insert: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser[0]
			##1 m_axis_tvalid
			|-> m_axis_tuser[3:1] == PH_HDR || m_axis_tuser[3:1] == PH_BODY
				|| m_axis_tuser[3:1] == PH_CSIZE || m_axis_tuser[3:1] == PH_REQ)
		else $error("phase jump after insert point");

	// a stalled transaction holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready
			|=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
				&& $stable(m_axis_tuser))
		else $error("output transaction changed while stalled");

endmodule

bind http_request_framing_parser_top hrfp_checker u_hrfp_checker (.*);
